/* rtl/core/linear_regression_minibatch_sgd_unit_assert.svh */
// Assertion macros for the minibatch SGD unit. Each one expects clk and arst_n in scope.
`ifndef LINEAR_REGRESSION_MINIBATCH_SGD_UNIT_ASSERT_SVH
`define LINEAR_REGRESSION_MINIBATCH_SGD_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LRS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/lrs_pkg.sv */
package lrs_pkg;

	localparam int DW = 32;
	localparam int CMD_W = 2;
	localparam int LR_W = 16;
	localparam int PROD_W = 48;
	localparam int GSUM_W = 56;
	localparam int ESUM_W = 40;
	localparam int SAT_W = 50;

	localparam int BATCH_DEF = 8;
	localparam int FEATURES_DEF = 3;
	localparam int MAX_FEATURES = 3;

	localparam logic [LR_W-1:0] LR_RESET = 16'd655;

	localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

	// Update step divider: the clamped quotient input is split into digits of DIV_DIGIT bits.
	localparam int DIV_W = 40;
	localparam int DIV_DIGIT = 4;
	localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int REM_W = 7;

	typedef struct packed {
		logic load;
		logic dot;
		logic sum;
		logic train;
		logic grad;
		logic mul;
		logic fold;
		logic div;
		logic upd;
	} lrs_ctrl_t;

	function automatic logic signed [DW-1:0] sat_word(input logic signed [SAT_W-1:0] v);
		logic signed [DW-1:0] r;
		if ((&v[SAT_W-1:DW-1]) || !(|v[SAT_W-1:DW-1])) begin
			r = v[DW-1:0];
		end else if (v[SAT_W-1]) begin
			r = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r = {1'b0, {(DW-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* rtl/core/lrs_if.sv */
interface lrs_req_if import lrs_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic signed [DW-1:0] x0;
	logic signed [DW-1:0] x1;
	logic signed [DW-1:0] x2;
	logic signed [DW-1:0] target;
	modport source(output valid, cmd, x0, x1, x2, target, input ready);
	modport sink(input valid, cmd, x0, x1, x2, target, output ready);
endinterface

interface lrs_rsp_if import lrs_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DW-1:0] prediction;
	logic signed [DW-1:0] residual;
	logic signed [DW-1:0] weight0;
	logic signed [DW-1:0] weight1;
	logic signed [DW-1:0] weight2;
	logic signed [DW-1:0] bias_out;
	logic batch_done;
	modport source(output valid, prediction, residual, weight0, weight1, weight2, bias_out,
		batch_done, input ready);
	modport sink(input valid, prediction, residual, weight0, weight1, weight2, bias_out,
		batch_done, output ready);
endinterface

interface lrs_cfg_if import lrs_pkg::*; ();
	logic valid;
	logic ready;
	logic [LR_W-1:0] learning_rate;
	modport source(output valid, learning_rate, input ready);
	modport sink(input valid, learning_rate, output ready);
endinterface

/* rtl/core/lrs_step.sv */
module lrs_step import lrs_pkg::*; #(
	parameter int BATCH = BATCH_DEF
) (
	input logic clk,
	input lrs_ctrl_t ctrl,
	input logic signed [GSUM_W-1:0] sum,
	input logic [LR_W:0] two_lr,
	output logic signed [DIV_W-1:0] step
);

	localparam logic [REM_W-1:0] DIVISOR = REM_W'(BATCH);

	logic [44:0] plo_s1;
	logic signed [45:0] phi_s1;
	logic signed [73:0] prod_full;
	logic signed [57:0] scaled;
	logic [57-DIV_W+1:0] hi_bits;
	logic [DIV_W-1:0] clamped;
	logic neg;
	logic [DIV_W-1:0] mag;
	logic [DIV_W-1:0] div_q;
	logic [REM_W-1:0] rem_q;
	logic neg_q;
	logic [DIV_W-1:0] div_next;
	logic [REM_W-1:0] rem_next;

	// The 56-bit sum is multiplied in two halves, then recombined.
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			plo_s1 <= 45'(sum[27:0]) * 45'(two_lr);
			phi_s1 <= $signed(sum[GSUM_W-1:28]) * $signed({1'b0, two_lr});
		end
	end

	assign prod_full = (74'(phi_s1) <<< 28) + 74'($signed({1'b0, plo_s1}));
	assign scaled = prod_full[73:16];
	assign hi_bits = scaled[57:DIV_W-1];

	// Beyond this range the weight saturates anyway, so the quotient may be clamped.
	always_comb begin
		if ((&hi_bits) || !(|hi_bits)) begin
			clamped = scaled[DIV_W-1:0];
		end else if (scaled[57]) begin
			clamped = {1'b1, {(DIV_W-1){1'b0}}};
		end else begin
			clamped = {1'b0, {(DIV_W-1){1'b1}}};
		end
	end

	// Floor division of a negative value is the complement of dividing its complement.
	assign neg = clamped[DIV_W-1];
	assign mag = neg ? ~clamped : clamped;

	always_comb begin
		rem_next = rem_q;
		div_next = div_q;
		for (int k = 0; k < DIV_DIGIT; k++) begin
			rem_next = {rem_next[REM_W-2:0], div_next[DIV_W-1]};
			div_next = {div_next[DIV_W-2:0], 1'b0};
			if (rem_next >= DIVISOR) begin
				rem_next = rem_next - DIVISOR;
				div_next[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fold) begin
			div_q <= mag;
			rem_q <= '0;
			neg_q <= neg;
		end else if (ctrl.div) begin
			div_q <= div_next;
			rem_q <= rem_next;
		end
	end

	assign step = neg_q ? $signed(~div_q) : $signed(div_q);

endmodule

/* rtl/core/lrs_lane.sv */
module lrs_lane import lrs_pkg::*; #(
	parameter int BATCH = BATCH_DEF
) (
	input logic clk,
	input logic arst_n,
	input lrs_ctrl_t ctrl,
	input logic signed [DW-1:0] x,
	input logic signed [DW-1:0] resid,
	input logic [LR_W:0] two_lr,
	output logic signed [PROD_W-1:0] prod_s1,
	output logic signed [DW-1:0] weight
);

	logic signed [DW-1:0] weight_q;
	logic signed [GSUM_W-1:0] gsum_q;
	logic signed [2*DW-1:0] dot_full;
	logic signed [2*DW-1:0] grad_full;
	logic signed [PROD_W-1:0] grad_term;
	logic signed [DIV_W-1:0] step;
	logic signed [DW-1:0] new_w;

	assign dot_full = weight_q * x;
	assign grad_full = x * resid;
	assign grad_term = $signed(grad_full[2*DW-1:16]);

	always_ff @(posedge clk) begin
		if (ctrl.dot) begin
			prod_s1 <= $signed(dot_full[2*DW-1:16]);
		end
	end

	lrs_step #(.BATCH(BATCH)) u_step (
		.clk(clk),
		.ctrl(ctrl),
		.sum(gsum_q),
		.two_lr(two_lr),
		.step(step)
	);

	assign new_w = sat_word(SAT_W'(weight_q) + SAT_W'(step));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
			gsum_q <= '0;
		end else if (ctrl.load) begin
			weight_q <= x;
			gsum_q <= '0;
		end else if (ctrl.grad) begin
			gsum_q <= gsum_q + GSUM_W'(grad_term);
		end else if (ctrl.upd) begin
			weight_q <= new_w;
			gsum_q <= '0;
		end
	end

	assign weight = weight_q;

endmodule

/* rtl/core/lrs_merge.sv */
module lrs_merge import lrs_pkg::*; #(
	parameter int BATCH = BATCH_DEF
) (
	input logic clk,
	input logic arst_n,
	input lrs_ctrl_t ctrl,
	input logic signed [PROD_W-1:0] prod [MAX_FEATURES],
	input logic signed [DW-1:0] target,
	input logic [LR_W:0] two_lr,
	output logic signed [DW-1:0] pred,
	output logic signed [DW-1:0] resid,
	output logic signed [DW-1:0] bias
);

	logic signed [DW-1:0] bias_q;
	logic signed [ESUM_W-1:0] esum_q;
	logic signed [DW-1:0] pred_q;
	logic signed [DW-1:0] resid_q;
	logic signed [SAT_W-1:0] acc;
	logic signed [DW-1:0] pred_w;
	logic signed [DW-1:0] resid_w;
	logic signed [DIV_W-1:0] step;
	logic signed [DW-1:0] new_b;

	always_comb begin
		acc = SAT_W'(bias_q);
		for (int i = 0; i < MAX_FEATURES; i++) begin
			acc = acc + SAT_W'(prod[i]);
		end
	end

	assign pred_w = sat_word(acc);
	assign resid_w = sat_word(SAT_W'(target) - SAT_W'(pred_w));

	lrs_step #(.BATCH(BATCH)) u_step (
		.clk(clk),
		.ctrl(ctrl),
		.sum(GSUM_W'(esum_q)),
		.two_lr(two_lr),
		.step(step)
	);

	assign new_b = sat_word(SAT_W'(bias_q) + SAT_W'(step));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			esum_q <= '0;
		end else if (ctrl.load) begin
			bias_q <= target;
			esum_q <= '0;
		end else if (ctrl.grad) begin
			esum_q <= esum_q + ESUM_W'(resid_q);
		end else if (ctrl.upd) begin
			bias_q <= new_b;
			esum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pred_q <= '0;
			resid_q <= '0;
		end else if (ctrl.sum) begin
			pred_q <= pred_w;
			resid_q <= ctrl.train ? resid_w : '0;
		end
	end

	assign pred = pred_q;
	assign resid = resid_q;
	assign bias = bias_q;

endmodule

/* rtl/core/linear_regression_minibatch_sgd_unit.sv */
// Channel  Role    Word carried
// req      sink    cmd, x0, x1, x2, target (one sample, train, predict or load command)
// rsp      source  prediction, residual, weight0..2, bias_out, batch_done
// cfg      sink    learning_rate (write only, always ready)
//
// Between acceptances a predict word passes S_DOT, S_SUM and S_OUT, a load S_DOT and S_OUT,
// a train word S_DOT, S_SUM, S_GRAD and S_OUT. One that closes a batch adds S_MUL (split
// multiply of the sums by the rate), S_FOLD, S_DIV (radix-16 divide by BATCH), S_UPD (commit).
// Reset clears the weights, bias, sums, batch count and restores learning_rate to 655.
// A stalled rsp holds its word; the next sample is taken meanwhile and waits in the last
// state until the output register frees up.

`include "linear_regression_minibatch_sgd_unit_assert.svh"

module linear_regression_minibatch_sgd_unit import lrs_pkg::*; #(
	parameter int BATCH = BATCH_DEF,
	parameter int FEATURES = FEATURES_DEF
) (
	input logic clk,
	input logic arst_n,
	lrs_req_if.sink req,
	lrs_rsp_if.source rsp,
	lrs_cfg_if.sink cfg
);

	localparam int CNT_W = (BATCH > 1) ? $clog2(BATCH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BATCH - 1);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	// Sequencer states. The accept happens in S_IDLE and the output register loads in S_OUT.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DOT = 4'd1;
	localparam logic [3:0] S_SUM = 4'd2;
	localparam logic [3:0] S_GRAD = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_FOLD = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_UPD = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [CMD_W-1:0] cmd_q;
	logic signed [DW-1:0] x_in [MAX_FEATURES];
	logic signed [DW-1:0] x_q [FEATURES];
	logic signed [DW-1:0] target_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic done_q;
	logic [LR_W-1:0] lr_q;
	logic [LR_W:0] two_lr;
	logic accept;
	logic out_free;
	logic out_valid_q;
	lrs_ctrl_t ctrl;

	logic signed [PROD_W-1:0] prod_all [MAX_FEATURES];
	logic signed [DW-1:0] weight_all [MAX_FEATURES];
	logic signed [DW-1:0] pred;
	logic signed [DW-1:0] resid;
	logic signed [DW-1:0] bias;

	logic signed [DW-1:0] pred_q;
	logic signed [DW-1:0] resid_q;
	logic signed [DW-1:0] w0_q;
	logic signed [DW-1:0] w1_q;
	logic signed [DW-1:0] w2_q;
	logic signed [DW-1:0] bias_out_q;
	logic batch_done_q;

	// The learning rate register. The user writes it only while the unit is idle; the block does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (cfg.valid) begin
			lr_q <= cfg.learning_rate;
		end
	end

	// Twice the rate folds the factor of two of the gradient into one multiplication.
	assign two_lr = {lr_q, 1'b0};

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign x_in[0] = req.x0;
	assign x_in[1] = req.x1;
	assign x_in[2] = req.x2;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			target_q <= req.target;
			for (int i = 0; i < FEATURES; i++) begin
				x_q[i] <= x_in[i];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DOT;
				end
			end
			S_DOT: begin
				state_d = (cmd_q == CMD_LOAD) ? S_OUT : S_SUM;
			end
			S_SUM: begin
				state_d = (cmd_q == CMD_TRAIN) ? S_GRAD : S_OUT;
			end
			S_GRAD: begin
				state_d = (cnt_q == CNT_LAST) ? S_MUL : S_OUT;
			end
			S_MUL: begin
				state_d = S_FOLD;
			end
			S_FOLD: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Lane and merge strobes. Every lane and the bias path run in lockstep.
	always_comb begin
		ctrl = '0;
		ctrl.load = (state_q == S_DOT) && (cmd_q == CMD_LOAD);
		ctrl.dot = (state_q == S_DOT) && (cmd_q != CMD_LOAD);
		ctrl.sum = (state_q == S_SUM);
		ctrl.train = (cmd_q == CMD_TRAIN);
		ctrl.grad = (state_q == S_GRAD);
		ctrl.mul = (state_q == S_MUL);
		ctrl.fold = (state_q == S_FOLD);
		ctrl.div = (state_q == S_DIV);
		ctrl.upd = (state_q == S_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			div_cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				done_q <= 1'b0;
			end
			if (ctrl.load) begin
				cnt_q <= '0;
			end else if (ctrl.grad) begin
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			if (ctrl.fold) begin
				div_cnt_q <= '0;
			end else if (ctrl.div) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (ctrl.upd) begin
				done_q <= 1'b1;
			end
		end
	end

	// One lane per feature. Lanes beyond FEATURES do not exist; their weights read zero.
	for (genvar g = 0; g < MAX_FEATURES; g++) begin : g_lane
		if (g < FEATURES) begin : g_on
			lrs_lane #(.BATCH(BATCH)) u_lane (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.x(x_q[g]),
				.resid(resid),
				.two_lr(two_lr),
				.prod_s1(prod_all[g]),
				.weight(weight_all[g])
			);
		end else begin : g_off
			assign prod_all[g] = '0;
			assign weight_all[g] = '0;
		end
	end

	// The merge stage adds the lane products to the bias, forms the residual and owns the bias.
	lrs_merge #(.BATCH(BATCH)) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.prod(prod_all),
		.target(target_q),
		.two_lr(two_lr),
		.pred(pred),
		.resid(resid),
		.bias(bias)
	);

	// The output register. It loads in S_OUT as soon as the previous word has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			pred_q <= pred;
			resid_q <= resid;
			w0_q <= weight_all[0];
			w1_q <= weight_all[1];
			w2_q <= weight_all[2];
			bias_out_q <= bias;
			batch_done_q <= done_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.prediction = pred_q;
	assign rsp.residual = resid_q;
	assign rsp.weight0 = w0_q;
	assign rsp.weight1 = w1_q;
	assign rsp.weight2 = w2_q;
	assign rsp.bias_out = bias_out_q;
	assign rsp.batch_done = batch_done_q;

	// A weight update runs only when the batch counter has just wrapped.
	`LRS_ASSERT_IMPLIES(a_upd_wrapped, state_q == S_UPD, cnt_q == '0, "update without batch wrap")
	// Only a train word can close a batch.
	`LRS_ASSERT_IMPLIES(a_done_train, (state_q == S_OUT) && done_q, cmd_q == CMD_TRAIN, "done on non-train word")
	// The divider always runs its full count before the commit.
	`LRS_ASSERT_NEXT(a_div_len, (state_q == S_DIV) && (div_cnt_q != DIV_LAST), state_q == S_DIV, "divider cut short")
	// Outside a train word the residual sent out is zero.
	`LRS_ASSERT_IMPLIES(a_resid_zero, (state_q == S_OUT) && (cmd_q != CMD_TRAIN), resid == '0, "residual set outside training")

endmodule

/* tb/tb_linear_regression_minibatch_sgd_unit.sv */
module tb_linear_regression_minibatch_sgd_unit;
	import lrs_pkg::*;

	// The block is built with its default sizes; the predictor follows the same values.
	localparam int BATCH = BATCH_DEF;
	localparam int FEATURES = FEATURES_DEF;

	// The command field has one code that the package leaves unnamed. It behaves as predict.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam logic signed [DW-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [DW-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [DW-1:0] Q_ONE = 32'sh00010000;

	// The long output stall must outlast the two words that the block can hold.
	localparam int HOLD_CYCLES = 300;
	// The slowest legal quiet stretch is the long stall plus one batch update
	// and a sender gap. The watchdog allows roughly ten times that.
	localparam int IDLE_LIMIT = 3000;
	// Quiet cycles at the end, comfortably past the longest train word.
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic signed [DW-1:0] x0;
		logic signed [DW-1:0] x1;
		logic signed [DW-1:0] x2;
		logic signed [DW-1:0] target;
	} sample_t;

	typedef struct packed {
		logic signed [DW-1:0] prediction;
		logic signed [DW-1:0] residual;
		logic signed [DW-1:0] weight0;
		logic signed [DW-1:0] weight1;
		logic signed [DW-1:0] weight2;
		logic signed [DW-1:0] bias_out;
		logic batch_done;
	} fit_result_t;

	logic clk;
	logic arst_n;

	lrs_req_if req_ch();
	lrs_rsp_if rsp_ch();
	lrs_cfg_if cfg_ch();

	linear_regression_minibatch_sgd_unit #(
		.BATCH(BATCH),
		.FEATURES(FEATURES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mirror of the trainer: weights, bias, the gradient and error sums, the fill of the
	// current batch and the learning rate. All arithmetic is done exactly in 64 bits.
	longint fit_weight[3];
	longint fit_bias;
	longint grad_acc[3];
	longint resid_acc;
	int batch_fill;
	logic [LR_W-1:0] step_rate;

	// Results still owed by the block, oldest first.
	fit_result_t pending_results[$];
	int err_count = 0;

	// Hidden linear relation from which the well-formed training words are drawn, so that
	// the weights move toward something and the batch updates stay meaningful.
	longint truth_w[3];
	longint truth_b;

	// Sender burst state, and the knobs that the back-pressure test uses.
	int burst_left = 0;
	bit no_gaps = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;

	function automatic longint sat_q(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// One update step: floor(sum * 2 * rate / (BATCH * 65536)). The sum is split at the
	// binary point so that the product never leaves 64 bits.
	function automatic longint update_step(input longint sum);
		longint two_rate;
		longint hi;
		longint lo;
		longint scaled;
		longint q;
		two_rate = longint'(step_rate) * 2;
		hi = sum >>> 16;
		lo = sum - hi * 65536;
		scaled = hi * two_rate + ((lo * two_rate) >>> 16);
		q = scaled / BATCH;
		if ((scaled % BATCH) != 0 && scaled < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic void clear_fit_state();
		int i;
		for (i = 0; i < 3; i++) begin
			fit_weight[i] = 0;
			grad_acc[i] = 0;
		end
		fit_bias = 0;
		resid_acc = 0;
		batch_fill = 0;
		step_rate = LR_RESET;
	endfunction

	// Advances the mirror by one accepted word and returns the result word it owes.
	function automatic fit_result_t apply_sample(input sample_t s);
		longint xv[3];
		longint tgt;
		longint acc;
		longint pred;
		longint resid;
		logic closed;
		fit_result_t r;
		int i;
		xv[0] = longint'($signed(s.x0));
		xv[1] = longint'($signed(s.x1));
		xv[2] = longint'($signed(s.x2));
		tgt = longint'($signed(s.target));
		pred = 0;
		resid = 0;
		closed = 1'b0;
		if (s.cmd == CMD_LOAD) begin
			// A load replaces the model and throws away the half-finished batch.
			for (i = 0; i < FEATURES; i++) begin
				fit_weight[i] = xv[i];
				grad_acc[i] = 0;
			end
			fit_bias = tgt;
			resid_acc = 0;
			batch_fill = 0;
		end else begin
			// Each product is floored to Q16.16 before the exact sum, then saturated.
			acc = fit_bias;
			for (i = 0; i < FEATURES; i++)
				acc = acc + ((fit_weight[i] * xv[i]) >>> 16);
			pred = sat_q(acc);
			if (s.cmd == CMD_TRAIN) begin
				resid = sat_q(tgt - pred);
				for (i = 0; i < FEATURES; i++)
					grad_acc[i] = grad_acc[i] + ((xv[i] * resid) >>> 16);
				resid_acc = resid_acc + resid;
				batch_fill++;
				if (batch_fill >= BATCH) begin
					// The weights were frozen for the whole batch; they move only here.
					for (i = 0; i < FEATURES; i++) begin
						fit_weight[i] = sat_q(fit_weight[i] + update_step(grad_acc[i]));
						grad_acc[i] = 0;
					end
					fit_bias = sat_q(fit_bias + update_step(resid_acc));
					resid_acc = 0;
					batch_fill = 0;
					closed = 1'b1;
				end
			end
		end
		r.prediction = pred[DW-1:0];
		r.residual = resid[DW-1:0];
		r.weight0 = fit_weight[0][DW-1:0];
		r.weight1 = fit_weight[1][DW-1:0];
		r.weight2 = fit_weight[2][DW-1:0];
		r.bias_out = fit_bias[DW-1:0];
		r.batch_done = closed;
		return r;
	endfunction

	// Mostly values of a few units in Q16.16, with the odd full-range or extreme value.
	function automatic logic signed [DW-1:0] pick_value(input int spread);
		logic [DW-1:0] raw;
		longint v;
		int r;
		r = $urandom_range(0, 15);
		raw = $urandom;
		if (r == 0)
			return raw;
		if (r == 1) begin
			case ($urandom_range(0, 3))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		v = longint'(raw & ((32'd1 << (spread + 1)) - 32'd1)) - (64'sd1 << spread);
		return v[DW-1:0];
	endfunction

	function automatic void new_truth();
		int i;
		for (i = 0; i < 3; i++)
			truth_w[i] = longint'($urandom_range(0, 1 << 19)) - (64'sd1 << 18);
		truth_b = longint'($urandom_range(0, 1 << 19)) - (64'sd1 << 18);
	endfunction

	// A training word whose label follows the hidden relation plus a little noise.
	function automatic sample_t make_train();
		sample_t s;
		longint acc;
		s.cmd = CMD_TRAIN;
		s.x0 = pick_value(19);
		s.x1 = pick_value(19);
		s.x2 = pick_value(19);
		acc = truth_b + longint'($urandom_range(0, 8191)) - 4096;
		acc = acc + ((truth_w[0] * longint'($signed(s.x0))) >>> 16);
		acc = acc + ((truth_w[1] * longint'($signed(s.x1))) >>> 16);
		acc = acc + ((truth_w[2] * longint'($signed(s.x2))) >>> 16);
		acc = sat_q(acc);
		s.target = acc[DW-1:0];
		return s;
	endfunction

	function automatic sample_t make_word(input logic [CMD_W-1:0] cmd,
			input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
			input logic signed [DW-1:0] c, input logic signed [DW-1:0] t);
		sample_t s;
		s.cmd = cmd;
		s.x0 = a;
		s.x1 = b;
		s.x2 = c;
		s.target = t;
		return s;
	endfunction

	// Offers one word, with a random gap first when the current burst has run out, and
	// records what the block owes for it once it is taken. Valid stays high after the
	// handshake so that back-to-back words need no extra edge.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = 0;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				if ($urandom_range(0, 3) == 0)
					burst_left = $urandom_range(40, 120);
				else
					burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= s.cmd;
		req_ch.x0 <= s.x0;
		req_ch.x1 <= s.x1;
		req_ch.x2 <= s.x2;
		req_ch.target <= s.target;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(apply_sample(s));
	endtask

	// Stops offering and waits for every owed result; the block is idle afterwards.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// The rate register is written only with nothing in flight.
	task automatic write_rate(input logic [LR_W-1:0] rate);
		cfg_ch.valid <= 1'b1;
		cfg_ch.learning_rate <= rate;
		do @(posedge clk); while (!cfg_ch.ready);
		step_rate = rate;
		cfg_ch.valid <= 1'b0;
	endtask

	// Zero weights out of reset: predict and train both see a zero prediction, and the
	// residual of a train word is its label.
	task automatic test_reset_values();
		send_sample(make_word(CMD_PREDICT, Q_ONE, Q_MAX, Q_MIN, Q_MAX));
		send_sample(make_word(CMD_TRAIN, Q_MIN, Q_ONE, Q_MAX, Q_MIN));
		drain_results();
	endtask

	// Loads at the extremes of the fields, then predictions that saturate both ways.
	// The unused command code must act as predict and report a zero residual.
	task automatic test_load_and_predict();
		send_sample(make_word(CMD_LOAD, Q_MAX, Q_MIN, Q_ONE, Q_MIN));
		send_sample(make_word(CMD_PREDICT, Q_MAX, Q_MAX, Q_MIN, '0));
		send_sample(make_word(CMD_UNUSED, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
		send_sample(make_word(CMD_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_sample(make_word(CMD_PREDICT, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
		send_sample(make_word(CMD_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_sample(make_word(CMD_PREDICT, Q_MAX, Q_MAX, Q_MAX, '1));
		drain_results();
	endtask

	// One full batch at the reset rate with extreme features and labels, so that the
	// residuals saturate and the update is large. Only the last word may close the batch.
	task automatic test_batch_extremes();
		int k;
		send_sample(make_word(CMD_LOAD, Q_ONE, -(Q_ONE / 2), 2 * Q_ONE, Q_ONE / 4));
		for (k = 0; k < BATCH; k++) begin
			if (k % 2 == 0)
				send_sample(make_word(CMD_TRAIN, Q_MAX, Q_MIN, Q_ONE, Q_MIN));
			else
				send_sample(make_word(CMD_TRAIN, Q_MIN, Q_MAX, '1, Q_MAX));
		end
		send_sample(make_word(CMD_PREDICT, Q_ONE, Q_ONE, Q_ONE, '0));
		drain_results();
	endtask

	// A load in the middle of a batch throws the partial sums away.
	task automatic test_load_clears_batch();
		int k;
		for (k = 0; k < 3; k++)
			send_sample(make_train());
		send_sample(make_word(CMD_LOAD, Q_ONE, Q_ONE, -Q_ONE, '0));
		send_sample(make_train());
		drain_results();
	endtask

	// The bulk of the run: mostly well-formed training words with random content, plus
	// noise words, predictions, the unused code and loads that land anywhere in a batch.
	task automatic test_random_stream(input logic [LR_W-1:0] rate, input int count);
		sample_t s;
		int k;
		int pick;
		write_rate(rate);
		new_truth();
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				s = make_train();
			end else if (pick < 82) begin
				s = make_word(CMD_TRAIN, $urandom, $urandom, $urandom, $urandom);
			end else if (pick < 89) begin
				s = make_word(CMD_PREDICT, pick_value(19), pick_value(19), pick_value(19),
					$urandom);
			end else if (pick < 92) begin
				s = make_word(CMD_UNUSED, pick_value(19), pick_value(19), pick_value(19),
					$urandom);
			end else if (pick < 97) begin
				s = make_word(CMD_LOAD, pick_value(18), pick_value(18), pick_value(18),
					pick_value(18));
			end else begin
				new_truth();
				s = make_train();
			end
			send_sample(s);
		end
		drain_results();
	endtask

	// The receiver stops for a long stretch while words keep coming with no gaps, so the
	// block fills up and has to stall its input; everything must come out in order.
	task automatic test_output_backpressure(input int count);
		int k;
		hold_request = 1'b1;
		no_gaps = 1'b1;
		for (k = 0; k < count; k++) begin
			if (k % 5 == 4)
				send_sample(make_word(CMD_PREDICT, pick_value(19), pick_value(19),
					pick_value(19), '0));
			else
				send_sample(make_train());
		end
		no_gaps = 1'b0;
		drain_results();
	endtask

	task automatic compare_field(input string name, input logic signed [DW-1:0] want,
			input logic signed [DW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	// Every result word taken from the block is matched against the oldest one owed.
	always @(posedge clk) begin : result_check
		fit_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result word with none expected, actual prediction %0d",
					$time, rsp_ch.prediction);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("prediction", want.prediction, rsp_ch.prediction);
				compare_field("residual", want.residual, rsp_ch.residual);
				compare_field("weight0", want.weight0, rsp_ch.weight0);
				compare_field("weight1", want.weight1, rsp_ch.weight1);
				compare_field("weight2", want.weight2, rsp_ch.weight2);
				compare_field("bias_out", want.bias_out, rsp_ch.bias_out);
				compare_field("batch_done", {31'd0, want.batch_done},
					{31'd0, rsp_ch.batch_done});
			end
		end
	end

	// Receiver stall pattern: runs of steady ready, coin flips, short stalls and a sparse
	// one-in-three pattern, with the long hold-off on request.
	initial begin : rsp_stall_pattern
		int seg_left;
		int seg_kind;
		seg_left = 0;
		seg_kind = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				seg_kind = 4;
				seg_left = HOLD_CYCLES;
			end else if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 3);
				case (seg_kind)
					0: seg_left = $urandom_range(20, 80);
					1: seg_left = $urandom_range(10, 40);
					2: seg_left = $urandom_range(1, 6);
					default: seg_left = $urandom_range(9, 30);
				endcase
			end
			seg_left--;
			case (seg_kind)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= $urandom_range(0, 1);
				3: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
				default: rsp_ch.ready <= 1'b0;
			endcase
		end
	end

	// Ends the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_linear_regression_minibatch_sgd_unit: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : main_sequence
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_PREDICT;
		req_ch.x0 <= '0;
		req_ch.x1 <= '0;
		req_ch.x2 <= '0;
		req_ch.target <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.learning_rate <= LR_RESET;
		clear_fit_state();
		new_truth();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, all at the rate that reset leaves in place.
		test_reset_values();
		test_load_and_predict();
		test_batch_extremes();
		test_load_clears_batch();

		// Random part across several rates, the extremes among them.
		test_random_stream(16'd0, 150);
		test_random_stream(16'hffff, 250);
		test_random_stream(16'd1, 120);
		test_random_stream(16'($urandom_range(2, 65534)), 300);
		test_output_backpressure(40);
		test_random_stream(LR_RESET, 560);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_linear_regression_minibatch_sgd_unit: clean");
		else
			$display("tb_linear_regression_minibatch_sgd_unit: errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lrs_pkg.sv
rtl/core/lrs_if.sv
rtl/core/lrs_step.sv
rtl/core/lrs_lane.sv
rtl/core/lrs_merge.sv
rtl/core/linear_regression_minibatch_sgd_unit.sv
tb/tb_linear_regression_minibatch_sgd_unit.sv
